/* rtl/core/cibc_pkg.sv */
// Shared types, codes and instruction decode helpers for the code image branch checker.
`timescale 1ns / 1ps
package cibc_pkg;

  localparam int ENTRY_SLOTS_DEF  = 8;
  localparam int UNSAFE_SLOTS_DEF = 64;

  localparam int WORD_W = 16;
  localparam int SLOT_W = 6;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 2;

  // Input commands, carried on in_tuser.
  localparam logic [CMD_W-1:0] CMD_RESTART   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_ENT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_UNS  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CHECK     = 2'd3;

  // Result status, carried on out_tuser.
  localparam logic [STAT_W-1:0] ST_PASSED   = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_ACCEPTED = 2'd2;
  localparam logic [STAT_W-1:0] ST_IGNORED  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_WORDS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNSAFE_COUNT = 2'd2;

  // Opcodes and decode masks.
  localparam logic [WORD_W-1:0] OP_JMP      = 16'h940C;
  localparam logic [WORD_W-1:0] OP_CALL     = 16'h940E;
  localparam logic [WORD_W-1:0] OP_RET      = 16'h9508;
  localparam logic [WORD_W-1:0] OP_RETI     = 16'h9518;
  localparam logic [WORD_W-1:0] OP_IJMP     = 16'h9409;
  localparam logic [WORD_W-1:0] OP_ICALL    = 16'h9509;
  localparam logic [WORD_W-1:0] OP_ELPM     = 16'h95D8;
  localparam logic [WORD_W-1:0] MASK_LPM    = 16'hFE0F;
  localparam logic [WORD_W-1:0] OP_ELPM_Z   = 16'h9006;
  localparam logic [WORD_W-1:0] OP_ELPM_ZP  = 16'h9007;
  localparam logic [WORD_W-1:0] MASK_BR     = 16'hF800;
  localparam logic [WORD_W-1:0] OP_BR       = 16'hF000;
  localparam logic [WORD_W-1:0] MASK_RJ     = 16'hE000;
  localparam logic [WORD_W-1:0] OP_RJ       = 16'hC000;

  // Control toward the target test unit.
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] target;
  } tu_ctl_t;

  // Answer from the target test unit.
  typedef struct packed {
    logic done;
    logic ok;
  } tu_res_t;

  function automatic logic is_long_op(input logic [WORD_W-1:0] w);
    return (w == OP_JMP) || (w == OP_CALL);
  endfunction

  function automatic logic is_unsafe_op(input logic [WORD_W-1:0] w);
    return (w == OP_RET) || (w == OP_RETI) || (w == OP_IJMP) || (w == OP_ICALL) ||
           (w == OP_ELPM) || ((w & MASK_LPM) == OP_ELPM_Z) ||
           ((w & MASK_LPM) == OP_ELPM_ZP);
  endfunction

  function automatic logic is_rel_op(input logic [WORD_W-1:0] w);
    return ((w & MASK_BR) == OP_BR) || ((w & MASK_RJ) == OP_RJ);
  endfunction

  // Sign-extended relative offset of a conditional branch or relative jump/call.
  function automatic logic [WORD_W-1:0] rel_offset(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] off;
    if ((w & MASK_BR) == OP_BR) begin
      off = {{9{w[9]}}, w[9:3]};
    end else begin
      off = {{4{w[11]}}, w[11:0]};
    end
    return off;
  endfunction

endpackage

/* rtl/core/cibc_tables.sv */
// Entrypoint and unsafe second-word tables with one write port and a registered read port.
`timescale 1ns / 1ps
module cibc_tables #(
  parameter int ENTRY_SLOTS  = cibc_pkg::ENTRY_SLOTS_DEF,
  parameter int UNSAFE_SLOTS = cibc_pkg::UNSAFE_SLOTS_DEF,
  parameter int NW           = 8
) (
  input  logic                        clk,
  input  logic                        ent_we,
  input  logic                        uns_we,
  input  logic [cibc_pkg::SLOT_W-1:0] wr_slot,
  input  logic [cibc_pkg::WORD_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic                        rd_sel_ent,
  input  logic [NW-1:0]               rd_idx,
  output logic [cibc_pkg::WORD_W-1:0] rd_data
);

  localparam int EAW = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
  localparam int UAW = (UNSAFE_SLOTS > 1) ? $clog2(UNSAFE_SLOTS) : 1;

  logic [cibc_pkg::WORD_W-1:0] ent_mem [ENTRY_SLOTS];
  logic [cibc_pkg::WORD_W-1:0] uns_mem [UNSAFE_SLOTS];
  logic [cibc_pkg::WORD_W-1:0] ent_q_r;
  logic [cibc_pkg::WORD_W-1:0] uns_q_r;
  logic                        sel_r;

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[EAW'(wr_slot)] <= wr_data;
    end
    if (rd_en) begin
      ent_q_r <= ent_mem[EAW'(rd_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (uns_we) begin
      uns_mem[UAW'(wr_slot)] <= wr_data;
    end
    if (rd_en) begin
      uns_q_r <= uns_mem[UAW'(rd_idx)];
      sel_r   <= rd_sel_ent;
    end
  end

  assign rd_data = sel_r ? ent_q_r : uns_q_r;

endmodule

/* rtl/core/cibc_target_unit.sv */
// Target test unit: walks one table with a single comparator to judge a branch target.
`timescale 1ns / 1ps
module cibc_target_unit #(
  parameter int NW = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [cibc_pkg::WORD_W-1:0] text_words,
  input  logic [NW-1:0]               ent_n,
  input  logic [NW-1:0]               uns_n,
  input  cibc_pkg::tu_ctl_t           ctl,
  output cibc_pkg::tu_res_t           res,
  output logic                        rd_en,
  output logic                        rd_sel_ent,
  output logic [NW-1:0]               rd_idx,
  input  logic [cibc_pkg::WORD_W-1:0] rd_data
);

  localparam logic U_IDLE = 1'b0;
  localparam logic U_WALK = 1'b1;

  logic                        st_r, st_nxt;
  logic [cibc_pkg::WORD_W-1:0] tgt_r, tgt_nxt;
  logic                        out_r, out_nxt;
  logic [NW-1:0]               n_r, n_nxt;
  logic [NW-1:0]               iss_r, iss_nxt;
  logic [NW-1:0]               cmp_r, cmp_nxt;
  logic                        dv_r, dv_nxt;
  logic                        outside;

  assign outside    = ctl.target >= text_words;
  assign rd_en      = (st_r == U_WALK) && (iss_r < n_r);
  assign rd_sel_ent = out_r;
  assign rd_idx     = iss_r;

  always_comb begin
    st_nxt   = st_r;
    tgt_nxt  = tgt_r;
    out_nxt  = out_r;
    n_nxt    = n_r;
    iss_nxt  = iss_r;
    cmp_nxt  = cmp_r;
    dv_nxt   = 1'b0;
    res.done = 1'b0;
    res.ok   = 1'b0;
    case (st_r)
      U_IDLE: begin
        if (ctl.start) begin
          tgt_nxt = ctl.target;
          out_nxt = outside;
          n_nxt   = outside ? ent_n : uns_n;
          iss_nxt = '0;
          cmp_nxt = '0;
          // Zero always matches outside the code, like the list terminator.
          if (outside && (ctl.target == '0)) begin
            res.done = 1'b1;
            res.ok   = 1'b1;
          end else if (n_nxt == '0) begin
            res.done = 1'b1;
            res.ok   = !outside;
          end else begin
            st_nxt = U_WALK;
          end
        end
      end
      U_WALK: begin
        if (rd_en) begin
          iss_nxt = iss_r + NW'(1);
          dv_nxt  = 1'b1;
        end
        if (dv_r) begin
          if (rd_data == tgt_r) begin
            res.done = 1'b1;
            res.ok   = out_r;
            st_nxt   = U_IDLE;
          end else if (cmp_r + NW'(1) == n_r) begin
            res.done = 1'b1;
            res.ok   = !out_r;
            st_nxt   = U_IDLE;
          end else begin
            cmp_nxt = cmp_r + NW'(1);
          end
        end
      end
      default: begin
        st_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= U_IDLE;
      dv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      dv_r <= dv_nxt;
    end
    tgt_r <= tgt_nxt;
    out_r <= out_nxt;
    n_r   <= n_nxt;
    iss_r <= iss_nxt;
    cmp_r <= cmp_nxt;
  end

endmodule

/* rtl/core/code_image_branch_checker_unit.sv */
// Restart and load transactions give no result. A check that is not answered at once (verdict
// already given, or scan address at or past the text end) runs three target tests in turn on
// one shared comparator, each answered at once or by a walk over the clamped table entries.
// The block takes one word at a time: no new word is accepted until its result is registered,
// and that waits while an earlier result has not been taken on out_tready.
// Reset (synchronous, rst_n low) clears scan state, configuration and handshakes; tables are kept.
`timescale 1ns / 1ps
module code_image_branch_checker_unit #(
  parameter int ENTRY_SLOTS  = cibc_pkg::ENTRY_SLOTS_DEF,
  parameter int UNSAFE_SLOTS = cibc_pkg::UNSAFE_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,   // slot [5:0], value [21:6], zero pad
  input  logic [cibc_pkg::CMD_W-1:0]     in_tuser,   // cmd [1:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [cibc_pkg::WORD_W-1:0]    out_tdata,  // word_address [15:0]
  output logic [cibc_pkg::STAT_W-1:0]    out_tuser,  // status [1:0]
  input  logic                           cfg_we,
  input  logic [cibc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cibc_pkg::WORD_W-1:0]    cfg_wdata
);

  localparam int MAXS = (ENTRY_SLOTS > UNSAFE_SLOTS) ? ENTRY_SLOTS : UNSAFE_SLOTS;
  localparam int NW   = $clog2(MAXS + 1);
  localparam int W    = cibc_pkg::WORD_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LAUNCH = 2'd1;
  localparam logic [1:0] S_WAIT   = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  localparam logic [1:0] T_WORD = 2'd0;
  localparam logic [1:0] T_ADDR = 2'd1;
  localparam logic [1:0] T_REL  = 2'd2;

  logic [1:0]                       state_r, state_nxt;
  logic [1:0]                       tsel_r, tsel_nxt;
  logic [2:0]                       ok_r, ok_nxt;
  logic [W-1:0]                     word_r, word_nxt;
  logic [W-1:0]                     addr_r, addr_nxt;
  logic [W-1:0]                     rel_r, rel_nxt;
  logic                             early_r, early_nxt;
  logic [cibc_pkg::STAT_W-1:0]      early_st_r, early_st_nxt;
  logic [W-1:0]                     scan_r, scan_nxt;
  logic                             lp_r, lp_nxt;
  logic                             verdict_r, verdict_nxt;
  logic [W-1:0]                     text_words_r, text_words_nxt;
  logic [3:0]                       entry_count_r, entry_count_nxt;
  logic [6:0]                       unsafe_count_r, unsafe_count_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [cibc_pkg::STAT_W-1:0]      out_status_r, out_status_nxt;
  logic [W-1:0]                     out_addr_r, out_addr_nxt;

  logic                             in_acc;
  logic [cibc_pkg::SLOT_W-1:0]      in_slot;
  logic [W-1:0]                     in_value;
  logic                             ent_we, uns_we;
  logic [NW-1:0]                    ent_n, uns_n;
  cibc_pkg::tu_ctl_t                tu_ctl;
  cibc_pkg::tu_res_t                tu_res;
  logic                             rd_en, rd_sel_ent;
  logic [NW-1:0]                    rd_idx;
  logic [W-1:0]                     rd_data;

  logic                             ok_w, ok_a, ok_t;
  logic                             rej;
  logic                             dec_lp;
  logic [W:0]                       next_addr;

  assign in_slot   = in_tdata[5:0];
  assign in_value  = in_tdata[21:6];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign ent_we = in_acc && (in_tuser == cibc_pkg::CMD_LOAD_ENT) && (int'(in_slot) < ENTRY_SLOTS);
  assign uns_we = in_acc && (in_tuser == cibc_pkg::CMD_LOAD_UNS) &&
                  (int'(in_slot) < UNSAFE_SLOTS);

  // Counts above the table depth count as the full table.
  assign ent_n = (int'(entry_count_r) > ENTRY_SLOTS) ? NW'(ENTRY_SLOTS) : NW'(entry_count_r);
  assign uns_n = (int'(unsafe_count_r) > UNSAFE_SLOTS) ? NW'(UNSAFE_SLOTS) :
                 NW'(unsafe_count_r);

  always_comb begin
    tu_ctl.start = (state_r == S_LAUNCH);
    case (tsel_r)
      T_WORD:  tu_ctl.target = word_r;
      T_ADDR:  tu_ctl.target = addr_r;
      default: tu_ctl.target = rel_r;
    endcase
  end

  cibc_tables #(
    .ENTRY_SLOTS  (ENTRY_SLOTS),
    .UNSAFE_SLOTS (UNSAFE_SLOTS),
    .NW           (NW)
  ) u_tables (
    .clk        (clk),
    .ent_we     (ent_we),
    .uns_we     (uns_we),
    .wr_slot    (in_slot),
    .wr_data    (in_value),
    .rd_en      (rd_en),
    .rd_sel_ent (rd_sel_ent),
    .rd_idx     (rd_idx),
    .rd_data    (rd_data)
  );

  cibc_target_unit #(
    .NW (NW)
  ) u_target (
    .clk        (clk),
    .rst_n      (rst_n),
    .text_words (text_words_r),
    .ent_n      (ent_n),
    .uns_n      (uns_n),
    .ctl        (tu_ctl),
    .res        (tu_res),
    .rd_en      (rd_en),
    .rd_sel_ent (rd_sel_ent),
    .rd_idx     (rd_idx),
    .rd_data    (rd_data)
  );

  // Verdict for one examined word from the three target test results.
  assign ok_w      = ok_r[0];
  assign ok_a      = ok_r[1];
  assign ok_t      = ok_r[2];
  assign next_addr = {1'b0, addr_r} + {{W{1'b0}}, 1'b1};

  always_comb begin
    rej    = 1'b0;
    dec_lp = 1'b0;
    if (lp_r && !ok_w) begin
      rej    = 1'b1;
      dec_lp = lp_r;
    end else if (cibc_pkg::is_long_op(word_r)) begin
      // As a long jump/call's second word, a long opcode clears the flag; rejected if ok_a.
      rej    = lp_r && ok_a;
      dec_lp = !lp_r;
    end else if (cibc_pkg::is_unsafe_op(word_r)) begin
      rej = !lp_r || ok_a;
    end else if (cibc_pkg::is_rel_op(word_r)) begin
      rej = !ok_t && (!lp_r || ok_a);
    end
  end

  always_comb begin
    state_nxt        = state_r;
    tsel_nxt         = tsel_r;
    ok_nxt           = ok_r;
    word_nxt         = word_r;
    addr_nxt         = addr_r;
    rel_nxt          = rel_r;
    early_nxt        = early_r;
    early_st_nxt     = early_st_r;
    scan_nxt         = scan_r;
    lp_nxt           = lp_r;
    verdict_nxt      = verdict_r;
    text_words_nxt   = text_words_r;
    entry_count_nxt  = entry_count_r;
    unsafe_count_nxt = unsafe_count_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_status_nxt   = out_status_r;
    out_addr_nxt     = out_addr_r;

    if (cfg_we) begin
      case (cfg_index)
        cibc_pkg::CFG_TEXT_WORDS:   text_words_nxt   = cfg_wdata;
        cibc_pkg::CFG_ENTRY_COUNT:  entry_count_nxt  = cfg_wdata[3:0];
        cibc_pkg::CFG_UNSAFE_COUNT: unsafe_count_nxt = cfg_wdata[6:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            cibc_pkg::CMD_RESTART: begin
              scan_nxt    = '0;
              lp_nxt      = 1'b0;
              verdict_nxt = 1'b0;
            end
            cibc_pkg::CMD_CHECK: begin
              word_nxt  = in_value;
              addr_nxt  = scan_r;
              rel_nxt   = scan_r + cibc_pkg::rel_offset(in_value) + W'(1);
              tsel_nxt  = T_WORD;
              ok_nxt    = '0;
              early_nxt = 1'b1;
              if (verdict_r) begin
                early_st_nxt = cibc_pkg::ST_IGNORED;
                state_nxt    = S_EMIT;
              end else if (scan_r >= text_words_r) begin
                early_st_nxt = cibc_pkg::ST_ACCEPTED;
                verdict_nxt  = 1'b1;
                state_nxt    = S_EMIT;
              end else begin
                early_nxt = 1'b0;
                state_nxt = S_LAUNCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_LAUNCH: begin
        if (tu_res.done) begin
          ok_nxt[tsel_r] = tu_res.ok;
          if (tsel_r == T_REL) begin
            state_nxt = S_EMIT;
          end else begin
            tsel_nxt = tsel_r + 2'd1;
          end
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (tu_res.done) begin
          ok_nxt[tsel_r] = tu_res.ok;
          if (tsel_r == T_REL) begin
            state_nxt = S_EMIT;
          end else begin
            tsel_nxt  = tsel_r + 2'd1;
            state_nxt = S_LAUNCH;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = addr_r;
          state_nxt     = S_IDLE;
          if (early_r) begin
            out_status_nxt = early_st_r;
          end else if (rej) begin
            out_status_nxt = cibc_pkg::ST_REJECTED;
            verdict_nxt    = 1'b1;
            lp_nxt         = dec_lp;
          end else begin
            lp_nxt   = dec_lp;
            scan_nxt = next_addr[W-1:0];
            if (next_addr >= {1'b0, text_words_r}) begin
              out_status_nxt = cibc_pkg::ST_ACCEPTED;
              verdict_nxt    = 1'b1;
            end else begin
              out_status_nxt = cibc_pkg::ST_PASSED;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      scan_r         <= '0;
      lp_r           <= 1'b0;
      verdict_r      <= 1'b0;
      text_words_r   <= '0;
      entry_count_r  <= '0;
      unsafe_count_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      scan_r         <= scan_nxt;
      lp_r           <= lp_nxt;
      verdict_r      <= verdict_nxt;
      text_words_r   <= text_words_nxt;
      entry_count_r  <= entry_count_nxt;
      unsafe_count_r <= unsafe_count_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    tsel_r       <= tsel_nxt;
    ok_r         <= ok_nxt;
    word_r       <= word_nxt;
    addr_r       <= addr_nxt;
    rel_r        <= rel_nxt;
    early_r      <= early_nxt;
    early_st_r   <= early_st_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_status_r;

endmodule

/* rtl/core/cibc_checker.sv */
// Port-level checker for the code image branch checker, bound to the top level.
`timescale 1ns / 1ps
module cibc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [cibc_pkg::CMD_W-1:0]     in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [cibc_pkg::WORD_W-1:0]    out_tdata,
  input logic [cibc_pkg::STAT_W-1:0]    out_tuser
);

  // A result that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // No result is shown right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // After a restart or load transaction the block is ready again in the next cycle.
  a_cmd_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != cibc_pkg::CMD_CHECK) |=> in_tready)
    else $error("non-check transaction did not finish in one cycle");

  // A check transaction occupies the block for at least the next cycle.
  a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == cibc_pkg::CMD_CHECK) |=> !in_tready)
    else $error("ready right after a check transaction");

endmodule

bind code_image_branch_checker_unit cibc_checker u_cibc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
